FILE: src/ccm_pkg.sv
// Shared types and constants for the card cipher MAC check unit.
package ccm_pkg;

  localparam int unsigned KeyW          = 64;
  localparam int unsigned ChallengeBits = 96;
  localparam int unsigned MacBits       = 32;
  localparam int unsigned TotalCycles   = ChallengeBits + MacBits;
  localparam int unsigned CntW          = $clog2(TotalCycles);

  localparam logic [15:0] TapInit   = 16'hE012;
  localparam logic [7:0]  FbInit    = 8'h4C;
  localparam logic [7:0]  KeyXor    = 8'h4C;
  localparam logic [7:0]  LeftAdd   = 8'hEC;
  localparam logic [7:0]  RightAdd  = 8'h21;

  // One input transfer
  typedef struct packed {
    logic [63:0] challenge_low;
    logic [31:0] challenge_high;
    logic [31:0] expected_mac;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [31:0] mac_value;
    logic        mac_equal;
  } out_item_t;

  // Cipher state moved through the tick unit
  typedef struct packed {
    logic [15:0] tap;
    logic [7:0]  fb;
    logic [7:0]  lb;
    logic [7:0]  rb;
  } cipher_state_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

endpackage

FILE: src/ccm_tick.sv
// Cipher tick unit: one step of the cipher state for one input bit.
module ccm_tick
  import ccm_pkg::*;
(
  input  cipher_state_t cur,
  input  logic          y,
  input  logic [63:0]   key,
  output cipher_state_t nxt
);

  logic       c0, c1, c2, c3, c4, c5, c6, c7;
  logic       tt, bt;
  logic       z0, z1, z2;
  logic [2:0] sel;
  logic [7:0] kb, fb_new, v, nr;

  always_comb begin
    // c0 is the msb of the right byte
    c0 = cur.rb[7]; c1 = cur.rb[6]; c2 = cur.rb[5]; c3 = cur.rb[4];
    c4 = cur.rb[3]; c5 = cur.rb[2]; c6 = cur.rb[1]; c7 = cur.rb[0];

    tt = cur.tap[15] ^ cur.tap[14] ^ cur.tap[10] ^ cur.tap[8]
       ^ cur.tap[5] ^ cur.tap[4] ^ cur.tap[1] ^ cur.tap[0];
    bt = cur.fb[6] ^ cur.fb[5] ^ cur.fb[4] ^ cur.fb[0];

    fb_new = {bt ^ c7, cur.fb[7:1]};

    z0 = (c0 & c2) ^ (c1 & ~c3) ^ (c2 | c4);
    z1 = (c0 | c2) ^ (c5 | c7) ^ c1 ^ c6 ^ tt ^ y;
    z2 = (c3 & ~c5) ^ (c4 & c6) ^ c7 ^ tt;
    sel = {z0, z1, z2};

    // key byte select
    kb = key[{sel, 3'b000} +: 8];
    v  = kb ^ fb_new;
    nr = v + cur.lb;

    nxt.tap = {tt ^ c0 ^ c4, cur.tap[15:1]};
    nxt.fb  = fb_new;
    nxt.rb  = nr;
    nxt.lb  = nr + cur.rb;
  end

endmodule

FILE: src/card_cipher_mac_check_unit.sv
// Top level: sequencer, state registers and result register around the tick unit.
// From the start transfer to the result strobe, the run does 96 challenge ticks, then 32 MAC
// bit captures with 31 blank ticks, one per cycle.
// A new start is taken only in idle; busy stays high for the whole run, then drops
// for the cycle in which the strobe shows and the next start can be taken.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (rst_n low, synchronous) clears the sequencer, strobe and key register.
module card_cipher_mac_check_unit
  import ccm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [KeyW-1:0] cfg_wdata
);

  seq_state_t           state_r, state_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [KeyW-1:0]      key_r;
  cipher_state_t        cs_r, cs_nxt, cs_tick;
  logic [ChallengeBits-1:0] chal_r, chal_nxt;
  logic [MacBits-1:0]   mac_r, mac_nxt, exp_r;
  logic                 out_strobe_r, out_strobe_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 accept, in_phase, last;
  logic                 tick_y;
  logic [7:0]           k0;

  assign accept   = start && (state_r == ST_IDLE);
  assign in_phase = (cnt_r < CntW'(ChallengeBits));
  assign last     = (cnt_r == CntW'(TotalCycles - 1));
  assign tick_y   = in_phase & chal_r[0];
  assign k0       = key_r[7:0] ^ KeyXor;

  ccm_tick u_tick (
    .cur (cs_r),
    .y   (tick_y),
    .key (key_r),
    .nxt (cs_tick)
  );

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cs_nxt         = cs_r;
    chal_nxt       = chal_r;
    mac_nxt        = mac_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          cs_nxt.tap = TapInit;
          cs_nxt.fb  = FbInit;
          cs_nxt.lb  = k0 + LeftAdd;
          cs_nxt.rb  = k0 + RightAdd;
          chal_nxt  = {in_item.challenge_high, in_item.challenge_low};
          mac_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (in_phase) begin
          chal_nxt = {1'b0, chal_r[ChallengeBits-1:1]};
          cs_nxt   = cs_tick;
        end else begin
          // capture MAC bit, lsb first through the top of the shifter
          mac_nxt = {cs_r.rb[2], mac_r[MacBits-1:1]};
          if (!last) begin
            cs_nxt = cs_tick;
          end
        end
        if (last) begin
          state_nxt              = ST_IDLE;
          out_strobe_nxt         = 1'b1;
          out_item_nxt.mac_value = mac_nxt;
          out_item_nxt.mac_equal = (mac_nxt == exp_r);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
      key_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        key_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cs_r       <= cs_nxt;
    chal_r     <= chal_nxt;
    mac_r      <= mac_nxt;
    out_item_r <= out_item_nxt;
    if (accept) begin
      exp_r <= in_item.expected_mac;
    end
  end

  assign busy       = (state_r == ST_RUN);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

FILE: sim/ccm_mac_checker.sv
// Checker for the card cipher MAC unit: tracks the key, predicts each MAC and compares results.
module ccm_mac_checker
  import ccm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  in_item_t        in_item,
  input  logic            out_strobe,
  input  out_item_t       out_item,
  input  logic            cfg_we,
  input  logic [KeyW-1:0] cfg_wdata,
  output int              fail_count,
  output int              macs_pending,
  output logic [31:0]     observed_mac
);

  logic [KeyW-1:0] key_shadow = '0;
  out_item_t       pending_macs[$];
  int              mismatches = 0;

  assign fail_count = mismatches;

  // Serial cipher: 96 challenge ticks, then 32 MAC bits with blank ticks in between
  function automatic logic [31:0] cipher_mac(input logic [KeyW-1:0] k, input logic [95:0] chal);
    logic [15:0] tap;
    logic [7:0]  fb, lb, rb, k0, v, nr;
    logic [31:0] mac;
    logic        c0, c1, c2, c3, c4, c5, c6, c7;
    logic        tt, bt, z0, z1, z2, y;
    logic [2:0]  sel;
    int          n;
    k0  = k[7:0] ^ KeyXor;
    tap = TapInit;
    fb  = FbInit;
    lb  = k0 + LeftAdd;
    rb  = k0 + RightAdd;
    mac = '0;
    for (n = 0; n < ChallengeBits + MacBits; n++) begin
      if (n >= ChallengeBits) begin
        mac[n - ChallengeBits] = rb[2];
      end
      if (n < ChallengeBits + MacBits - 1) begin
        y  = (n < ChallengeBits) ? chal[n] : 1'b0;
        c0 = rb[7]; c1 = rb[6]; c2 = rb[5]; c3 = rb[4];
        c4 = rb[3]; c5 = rb[2]; c6 = rb[1]; c7 = rb[0];
        tt = ^{tap[15], tap[14], tap[10], tap[8], tap[5], tap[4], tap[1], tap[0]};
        bt = ^{fb[6], fb[5], fb[4], fb[0]};
        tap = {tt ^ c0 ^ c4, tap[15:1]};
        fb  = {bt ^ c7, fb[7:1]};
        z0  = (c0 & c2) ^ (c1 & ~c3) ^ (c2 | c4);
        z1  = (c0 | c2) ^ (c5 | c7) ^ c1 ^ c6 ^ tt ^ y;
        z2  = (c3 & ~c5) ^ (c4 & c6) ^ c7 ^ tt;
        sel = {z0, z1, z2};
        // key byte picked by z, mixed with the updated feedback byte
        v   = k[sel*8 +: 8] ^ fb;
        nr  = v + lb;
        lb  = nr + rb;
        rb  = nr;
      end
    end
    return mac;
  endfunction

  // Watch start transfers, key writes and result strobes
  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst_n) begin
      key_shadow = '0;
    end else begin
      // a start taken at the same edge as a key write still sees the old key
      if (start && !busy) begin
        want.mac_value = cipher_mac(key_shadow, {in_item.challenge_high, in_item.challenge_low});
        want.mac_equal = (want.mac_value == in_item.expected_mac);
        pending_macs.push_back(want);
      end
      if (cfg_we) begin
        key_shadow = cfg_wdata;
      end
      if (out_strobe) begin
        got = out_item;
        observed_mac <= got.mac_value;
        if (pending_macs.size() == 0) begin
          $error("result transfer with no MAC pending: mac_value %h mac_equal %b",
                 got.mac_value, got.mac_equal);
          mismatches++;
        end else begin
          want = pending_macs.pop_front();
          if (got.mac_value !== want.mac_value) begin
            $error("mac_value: expected %h, got %h", want.mac_value, got.mac_value);
            mismatches++;
          end
          if (got.mac_equal !== want.mac_equal) begin
            $error("mac_equal: expected %b, got %b", want.mac_equal, got.mac_equal);
            mismatches++;
          end
        end
      end
    end
    macs_pending <= pending_macs.size();
  end

endmodule

FILE: sim/tb_card_cipher_mac_check_unit.sv
// Testbench top for the card cipher MAC unit: clock, reset, key phases and challenge stimulus.
module tb_card_cipher_mac_check_unit;
  import ccm_pkg::*;

  localparam int LimitCycles  = 1_500_000;
  localparam int ItemsPerKey  = 142;
  localparam int NumKeyPhases = 6;
  localparam int TailCycles   = TotalCycles + 16;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_item_t        in_item = '0;
  logic            out_strobe;
  out_item_t       out_item;
  logic            cfg_we = 1'b0;
  logic [KeyW-1:0] cfg_wdata = '0;

  int              fail_count;
  int              macs_pending;
  logic [31:0]     observed_mac;
  int              cycle_count = 0;
  in_item_t        last_item = '0;
  int              burst_left = 0;

  card_cipher_mac_check_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  ccm_mac_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_strobe   (out_strobe),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .macs_pending (macs_pending),
    .observed_mac (observed_mac)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t mk_item(input logic [63:0] lo, input logic [31:0] hi,
                                       input logic [31:0] mac);
    in_item_t it;
    it.challenge_low  = lo;
    it.challenge_high = hi;
    it.expected_mac   = mac;
    return it;
  endfunction

  // Hold start until the unit takes the transfer; start stays high for the caller
  task automatic send(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    last_item = it;
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Pause the sender until every pending MAC has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (macs_pending != 0);
  endtask

  task automatic write_key(input logic [KeyW-1:0] k);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Resend the last challenge, expecting the MAC just seen, optionally one bit off
  task automatic send_echo(input bit near_miss);
    in_item_t it;
    drain();
    it = last_item;
    it.expected_mac = observed_mac;
    if (near_miss) begin
      it.expected_mac[$urandom_range(0, 31)] ^= 1'b1;
    end
    send(it);
  endtask

  task automatic run_directed();
    write_key('0);
    send(mk_item('0, '0, '0));
    send(mk_item('1, '1, '1));
    send(mk_item(64'h1, '0, $urandom));
    idle($urandom_range(1, 60));
    send(mk_item('0, 32'h8000_0000, $urandom));
    send(mk_item('1, '0, '0));
    send(mk_item('0, '1, '1));
    send_echo(1'b0);
    send_echo(1'b1);

    write_key('1);
    send(mk_item('0, '0, '0));
    send(mk_item('1, '1, '1));
    send_echo(1'b0);
    send_echo(1'b1);

    // key byte 0 that cancels the init mask
    write_key(64'hA5A5_5A5A_0F0F_F04C);
    send(mk_item({$urandom, $urandom}, $urandom, $urandom));
    send_echo(1'b0);

    // key byte 0 that makes the init byte all ones
    write_key(64'h0123_4567_89AB_CDB3);
    send(mk_item({$urandom, $urandom}, $urandom, $urandom));
    send_echo(1'b0);
    send_echo(1'b1);
  endtask

  task automatic run_random(input int count);
    int          kind;
    logic [63:0] lo;
    logic [31:0] hi;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          idle($urandom_range(1, 200));
        end else begin
          idle($urandom_range(1, 20));
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
      end
      kind = $urandom_range(0, 7);
      if (kind <= 1) begin
        send_echo(1'b0);
      end else if (kind == 2) begin
        send_echo(1'b1);
      end else begin
        lo = {$urandom, $urandom};
        hi = $urandom;
        // sparse or saturated challenges now and then
        case ($urandom_range(0, 15))
          0: begin lo = '0; hi = '0; end
          1: begin lo = '1; hi = '1; end
          2: begin lo = lo & {$urandom, $urandom}; hi = hi & $urandom; end
          default: ;
        endcase
        send(mk_item(lo, hi, $urandom));
      end
      burst_left--;
    end
  endtask

  initial begin
    logic [KeyW-1:0] k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < NumKeyPhases; p++) begin
      k = {$urandom, $urandom};
      case (p)
        1: k = '1;
        2: k[7:0] = KeyXor;
        3: k[7:0] = ~KeyXor;
        4: k = '0;
        default: ;
      endcase
      write_key(k);
      run_random(ItemsPerKey);
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && macs_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ccm_pkg.sv
src/ccm_tick.sv
src/card_cipher_mac_check_unit.sv
sim/ccm_mac_checker.sv
sim/tb_card_cipher_mac_check_unit.sv
